FILE: rtl/msps_pkg.sv
// Shared constants, types and helpers of the multi-strategy process scheduler.
`default_nettype none

package msps_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int AGE_BITS  = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int PRIO_W    = 8;
   localparam int MASK_W    = 8;
   localparam int ID_W      = 3;
   localparam int PRIOS_W   = 64;

   localparam logic [1:0] CMD_SCHEDULE    = 2'd0;
   localparam logic [1:0] CMD_CLEAR_AGE   = 2'd1;
   localparam logic [1:0] CMD_RESET_STATE = 2'd2;

   localparam logic [1:0] STRAT_EVEN  = 2'd0;
   localparam logic [1:0] STRAT_RR    = 2'd1;
   localparam logic [1:0] STRAT_AGING = 2'd2;
   localparam logic [1:0] STRAT_RTC   = 2'd3;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_STRATEGY = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                have;
      logic [SLOT_W-1:0]   id;
      logic [AGE_BITS-1:0] age;
      logic [PRIO_W-1:0]   prio;
   } best_type;

   // Priority of slot s; slots without a byte in the packed word read as zero.
   function automatic logic [PRIO_W-1:0] prio_of(input logic [PRIOS_W-1:0] pr, input int s);
      logic [PRIO_W-1:0] p;
      p = '0;
      if (s < PRIOS_W / PRIO_W && s >= 0) begin
         p = pr[PRIO_W*s +: PRIO_W];
      end
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/msps_age_alu.sv
// Shared aging unit: saturating age update and oldest-slot compare for one slot.
`default_nettype none

module msps_age_alu
   import msps_pkg::*;
(
   input  wire logic [AGE_BITS-1:0] age,
   input  wire logic [PRIO_W-1:0]   prio,
   input  wire logic                do_add,
   input  wire logic                cand,
   input  wire best_type            best,
   output logic [AGE_BITS-1:0]      new_age,
   output logic                     take
);

   logic [AGE_BITS:0] sum;

   always_comb begin
      sum = {1'b0, age} + {{(AGE_BITS + 1 - PRIO_W){1'b0}}, prio};
      if (!do_add) begin
         new_age = age;
      end else if (sum[AGE_BITS]) begin
         new_age = '1;
      end else begin
         new_age = sum[AGE_BITS-1:0];
      end
      // strict compares keep the lower slot on a full tie
      take = cand && (!best.have || (best.age < new_age) ||
                      ((best.age == new_age) && (best.prio < prio)));
   end

endmodule

`default_nettype wire

FILE: rtl/multi_strategy_process_scheduler.sv
// A schedule request is taken into the EXEC state, which registers rsp_valid and rsp_next_id
// under even, round robin, run to completion or with no slot ready; clear-age, reset-state
// and unknown commands give no result. Both keep busy high for one cycle; start is ignored while busy.
// Aging with a slot ready walks one slot per cycle through the shared add/compare unit in WALK,
// then gives its result from FINISH; busy stays high from EXEC through WALK and FINISH.
// Receiver cannot stall. Reset (synchronous, active high) clears strategy, slice and all ages.
`default_nettype none

module multi_strategy_process_scheduler
   import msps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [MASK_W-1:0]  req_ready_mask,
   input  wire logic               req_current_unused,
   input  wire logic [ID_W-1:0]    req_current_id,
   input  wire logic [ID_W-1:0]    req_slot,
   input  wire logic [PRIOS_W-1:0] req_priorities,
   // result channel
   output logic                    rsp_valid,
   output logic [ID_W-1:0]         rsp_next_id,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   state_type state_ff, state_in;

   logic [1:0]          strategy_ff;
   logic [PRIO_W-1:0]   slice_ff, slice_in;
   logic [AGE_BITS-1:0] age_ff [NUM_SLOTS];

   logic [1:0]          cmd_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                unused_ff;
   logic [ID_W-1:0]     cur_ff;
   logic [ID_W-1:0]     slot_ff;
   logic [PRIOS_W-1:0]  prio_ff;

   logic [SLOT_W-1:0]   idx_ff, idx_in;
   best_type            best_ff, best_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;

   logic [NUM_SLOTS-1:0] ready_vec;
   logic                 cur_ready;
   logic [SLOT_W-1:0]    hi_id, lo_id, even_id;
   logic                 hi_found, lo_found;

   logic [NUM_SLOTS-1:0] age_we;
   logic [AGE_BITS-1:0]  age_wd;
   logic                 age_clear_all;

   logic [PRIO_W-1:0]    walk_prio;
   logic [AGE_BITS-1:0]  walk_age;
   logic                 walk_add;
   logic                 walk_cand;
   logic [AGE_BITS-1:0]  walk_new_age;
   logic                 walk_take;
   logic [PRIO_W-1:0]    slice_dec;
   logic                 accept;
   logic                 cfg_write;

   function automatic logic req_unused_or_expired(input logic unused,
                                                  input logic [PRIO_W-1:0] left);
      return unused || (left == '0);
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_id = rsp_id_ff;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == CSR_IDX_STRATEGY) ? {30'd0, strategy_ff} : 32'd0;

   // ready bits and even scan over the latched mask
   always_comb begin
      ready_vec = '0;
      cur_ready = 1'b0;
      hi_id     = '0;
      lo_id     = '0;
      hi_found  = 1'b0;
      lo_found  = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (i < MASK_W) begin
            ready_vec[i] = mask_ff[i % MASK_W];
         end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (i == int'(cur_ff) && ready_vec[i]) begin
            cur_ready = 1'b1;
         end
      end
      for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
         if (ready_vec[i]) begin
            if (i > int'(cur_ff)) begin
               hi_id    = SLOT_W'(i);
               hi_found = 1'b1;
            end else begin
               lo_id    = SLOT_W'(i);
               lo_found = 1'b1;
            end
         end
      end
      if (hi_found) begin
         even_id = hi_id;
      end else if (lo_found) begin
         even_id = lo_id;
      end else begin
         even_id = '0;
      end
   end

   assign walk_age  = age_ff[idx_ff];
   assign walk_prio = prio_of(prio_ff, int'(idx_ff));
   assign walk_add  = ready_vec[idx_ff] && (int'(idx_ff) != int'(cur_ff));
   assign walk_cand = ready_vec[idx_ff] && (idx_ff != '0);
   assign slice_dec = slice_ff - PRIO_W'(1);

   msps_age_alu u_age_alu (
      .age     (walk_age),
      .prio    (walk_prio),
      .do_add  (walk_add),
      .cand    (walk_cand),
      .best    (best_ff),
      .new_age (walk_new_age),
      .take    (walk_take)
   );

   always_comb begin
      state_in      = state_ff;
      slice_in      = slice_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      rsp_valid_in  = 1'b0;
      rsp_id_in     = rsp_id_ff;
      age_we        = '0;
      age_wd        = '0;
      age_clear_all = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_CLEAR_AGE: begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (i == int'(slot_ff)) begin
                        age_we[i] = 1'b1;
                     end
                  end
               end
               CMD_RESET_STATE: begin
                  if (strategy_ff == STRAT_RR) begin
                     slice_in = prio_of(prio_ff, int'(cur_ff));
                  end else if (strategy_ff == STRAT_AGING) begin
                     age_clear_all = 1'b1;
                  end
               end
               CMD_SCHEDULE: begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = ID_W'(even_id);
                  if (even_id != '0) begin
                     case (strategy_ff)
                        STRAT_RR: begin
                           if (req_unused_or_expired(unused_ff, slice_dec)) begin
                              slice_in = prio_of(prio_ff, int'(even_id));
                           end else begin
                              slice_in  = slice_dec;
                              rsp_id_in = cur_ff;
                           end
                        end
                        STRAT_AGING: begin
                           // hold the result until the walk is done
                           rsp_valid_in = 1'b0;
                           idx_in       = '0;
                           best_in      = '0;
                           state_in     = ST_WALK;
                        end
                        STRAT_RTC: begin
                           if (cur_ready) begin
                              rsp_id_in = cur_ff;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
         end
         ST_WALK: begin
            if (walk_add) begin
               age_we[idx_ff] = 1'b1;
               age_wd         = walk_new_age;
            end
            if (walk_take) begin
               best_in = '{have: 1'b1, id: idx_ff, age: walk_new_age, prio: walk_prio};
            end
            if (idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_FINISH: begin
            age_we[best_ff.id] = 1'b1;
            age_wd       = {{(AGE_BITS - PRIO_W){1'b0}}, best_ff.prio};
            rsp_valid_in = 1'b1;
            rsp_id_in    = ID_W'(best_ff.id);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         strategy_ff  <= STRAT_EVEN;
         slice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slice_ff     <= slice_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write && paddr[2] == CSR_IDX_STRATEGY) begin
            strategy_ff <= pwdata[1:0];
         end
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (age_clear_all) begin
               age_ff[i] <= '0;
            end else if (age_we[i]) begin
               age_ff[i] <= age_wd;
            end
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      rsp_id_ff <= rsp_id_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         mask_ff   <= req_ready_mask;
         unused_ff <= req_current_unused;
         cur_ff    <= req_current_id;
         slot_ff   <= req_slot;
         prio_ff   <= req_priorities;
      end
   end

`ifndef SYNTHESIS
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_FINISH))
      else $error("result strobe without a finishing step");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted transfer did not start execution");

   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && idx_ff != SLOT_W'(NUM_SLOTS - 1))
         |=> (state_ff == ST_WALK && idx_ff == $past(idx_ff) + SLOT_W'(1)))
      else $error("aging walk skipped a slot");

   a_finish_has_winner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (best_ff.have && best_ff.id != '0))
      else $error("aging walk ended without a ready slot");
`endif

endmodule

`default_nettype wire

FILE: test/tb_multi_strategy_process_scheduler.sv
// Self-checking testbench: predicts every slot pick of the scheduler under all four strategies.
`timescale 1ns / 1ps

module tb_multi_strategy_process_scheduler;
   import msps_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN       = 2'd3;
   localparam logic [2:0] ADDR_STRATEGY     = 3'd0;
   localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
   localparam int         AGE_MAX           = (1 << AGE_BITS) - 1;
   localparam int         SETTLE_CYCLES     = 2 * (NUM_SLOTS + 3);
   localparam int         QUIET_LIMIT       = 2000;
   localparam int         PHASES            = 8;
   localparam int         REQUESTS_PER_PHASE = 210;

   typedef struct {
      logic [1:0]         cmd;
      logic [MASK_W-1:0]  ready_mask;
      logic               current_unused;
      logic [ID_W-1:0]    current_id;
      logic [ID_W-1:0]    slot;
      logic [PRIOS_W-1:0] priorities;
   } request_type;

   class slot_pick_board;
      logic [1:0]          strategy;
      logic [AGE_BITS-1:0] slot_age [NUM_SLOTS];
      logic [7:0]          slice_left;
      logic [ID_W-1:0]     pending_picks [$];
      logic [ID_W-1:0]     last_pick;
      int                  errors;
      int                  picks_checked;

      function new();
         strategy      = STRAT_EVEN;
         slice_left    = '0;
         last_pick     = '0;
         errors        = 0;
         picks_checked = 0;
         foreach (slot_age[i]) slot_age[i] = '0;
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      function logic [PRIO_W-1:0] slot_prio(input logic [PRIOS_W-1:0] pr, input int s);
         return (s < 8) ? pr[PRIO_W*s +: PRIO_W] : '0;
      endfunction

      function bit slot_ready(input logic [MASK_W-1:0] mask, input int s);
         return s < NUM_SLOTS && s < MASK_W && mask[s];
      endfunction

      // Cyclic scan after the current slot; slot 0 is never taken here.
      function int scan_after(input logic [MASK_W-1:0] mask, input int cur);
         for (int i = cur + 1; i < NUM_SLOTS; i++)
            if (slot_ready(mask, i)) return i;
         for (int i = 1; i <= cur && i < NUM_SLOTS; i++)
            if (slot_ready(mask, i)) return i;
         return 0;
      endfunction

      function int oldest_ready(input logic [MASK_W-1:0] mask, input int cur,
                                input logic [PRIOS_W-1:0] pr);
         int sum;
         int best;
         bit found;
         best  = 0;
         found = 0;
         // age every waiting slot, saturating
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_ready(mask, i) && i != cur) begin
               sum = int'(slot_age[i]) + int'(slot_prio(pr, i));
               slot_age[i] = (sum > AGE_MAX) ? AGE_MAX[AGE_BITS-1:0] : sum[AGE_BITS-1:0];
            end
         end
         // oldest wins, then higher priority, then lower slot
         for (int i = 1; i < NUM_SLOTS; i++) begin
            if (slot_ready(mask, i)) begin
               if (!found || slot_age[best] < slot_age[i] ||
                   (slot_age[best] == slot_age[i] && slot_prio(pr, best) < slot_prio(pr, i))) begin
                  best  = i;
                  found = 1;
               end
            end
         end
         slot_age[best] = AGE_BITS'(slot_prio(pr, best));
         return best;
      endfunction

      function void note_request(input request_type r);
         int pick;
         int cur;
         cur = r.current_id;
         case (r.cmd)
            CMD_CLEAR_AGE: begin
               if (r.slot < NUM_SLOTS) slot_age[r.slot] = '0;
            end
            CMD_RESET_STATE: begin
               if (strategy == STRAT_RR) slice_left = slot_prio(r.priorities, cur);
               else if (strategy == STRAT_AGING) foreach (slot_age[i]) slot_age[i] = '0;
            end
            CMD_SCHEDULE: begin
               pick = scan_after(r.ready_mask, cur);
               if (pick != 0) begin
                  case (strategy)
                     STRAT_RR: begin
                        slice_left = slice_left - 8'd1;
                        if (r.current_unused || slice_left == 8'd0)
                           slice_left = slot_prio(r.priorities, pick);
                        else
                           pick = cur;
                     end
                     STRAT_AGING: pick = oldest_ready(r.ready_mask, cur, r.priorities);
                     STRAT_RTC: if (slot_ready(r.ready_mask, cur)) pick = cur;
                     default: ;
                  endcase
               end
               last_pick = pick[ID_W-1:0];
               pending_picks.push_back(pick[ID_W-1:0]);
            end
            default: ;
         endcase
      endfunction

      task check_pick(input logic [ID_W-1:0] got);
         logic [ID_W-1:0] want;
         if (pending_picks.size() == 0) begin
            report($sformatf("next_id %0d with no request outstanding", got));
         end else begin
            want = pending_picks.pop_front();
            picks_checked++;
            if (got !== want) report($sformatf("next_id %0d, predicted %0d", got, want));
         end
      endtask
   endclass

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               start              = 1'b0;
   logic               busy;
   logic [1:0]         req_cmd            = '0;
   logic [MASK_W-1:0]  req_ready_mask     = '0;
   logic               req_current_unused = 1'b0;
   logic [ID_W-1:0]    req_current_id     = '0;
   logic [ID_W-1:0]    req_slot           = '0;
   logic [PRIOS_W-1:0] req_priorities     = '0;
   logic               rsp_valid;
   logic [ID_W-1:0]    rsp_next_id;
   logic               psel               = 1'b0;
   logic               penable            = 1'b0;
   logic               pwrite             = 1'b0;
   logic [2:0]         paddr              = '0;
   logic [31:0]        pwdata             = '0;
   logic [31:0]        prdata;
   logic               pready;

   slot_pick_board sb = new();
   int             requests_sent = 0;
   int             csr_writes    = 0;
   int             quiet_cycles  = 0;
   int             idle_pct      = 0;

   multi_strategy_process_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_ready_mask     (req_ready_mask),
      .req_current_unused (req_current_unused),
      .req_current_id     (req_current_id),
      .req_slot           (req_slot),
      .req_priorities     (req_priorities),
      .rsp_valid          (rsp_valid),
      .rsp_next_id        (rsp_next_id),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_pick(rsp_next_id);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold the request until the edge that takes it; leave start high afterwards.
   task automatic send_request(input request_type r, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_cmd            <= r.cmd;
      req_ready_mask     <= r.ready_mask;
      req_current_unused <= r.current_unused;
      req_current_id     <= r.current_id;
      req_slot           <= r.slot;
      req_priorities     <= r.priorities;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      requests_sent++;
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [MASK_W-1:0] mask,
                              input logic unused, input logic [ID_W-1:0] cur,
                              input logic [ID_W-1:0] slot, input logic [PRIOS_W-1:0] pr);
      request_type r;
      r.cmd            = cmd;
      r.ready_mask     = mask;
      r.current_unused = unused;
      r.current_id     = cur;
      r.slot           = slot;
      r.priorities     = pr;
      send_request(r, 0);
   endtask

   // Drop start and wait until every pick has come back and the aging walk has ended.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata   = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_strategy(input logic [2:0] addr, input logic [1:0] value);
      logic [31:0] rd;
      drain();
      csr_access(addr, 1'b1, {30'd0, value}, rd);
      csr_writes++;
      if (addr == ADDR_STRATEGY) sb.strategy = value;
      csr_access(ADDR_STRATEGY, 1'b0, '0, rd);
      if (rd[1:0] !== sb.strategy)
         sb.report($sformatf("strategy reads %0d, expected %0d", rd[1:0], sb.strategy));
   endtask

   function automatic request_type random_request();
      request_type r;
      int pick;
      int b;
      pick = $urandom_range(99);
      if (pick < 82)      r.cmd = CMD_SCHEDULE;
      else if (pick < 89) r.cmd = CMD_CLEAR_AGE;
      else if (pick < 95) r.cmd = CMD_RESET_STATE;
      else                r.cmd = CMD_UNKNOWN;
      case ($urandom_range(9))
         0:       r.ready_mask = '0;
         1:       r.ready_mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
         2:       r.ready_mask = '1;
         default: r.ready_mask = MASK_W'($urandom);
      endcase
      // mostly follow the scheduler's own last choice, as a kernel would
      r.current_id     = ($urandom_range(9) < 7) ? sb.last_pick : ID_W'($urandom_range(7));
      r.current_unused = ($urandom_range(4) == 0);
      r.slot           = ID_W'($urandom_range(7));
      for (int i = 0; i < PRIOS_W / PRIO_W; i++) begin
         b = $urandom_range(99);
         if (b < 60)      r.priorities[PRIO_W*i +: PRIO_W] = PRIO_W'($urandom_range(1, 4));
         else if (b < 75) r.priorities[PRIO_W*i +: PRIO_W] = '0;
         else if (b < 90) r.priorities[PRIO_W*i +: PRIO_W] = '1;
         else             r.priorities[PRIO_W*i +: PRIO_W] = PRIO_W'($urandom);
      end
      return r;
   endfunction

   initial begin
      logic [31:0] rd;
      int gap;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // strategy must come up as even; a write to an unmapped index changes nothing
      csr_access(ADDR_STRATEGY, 1'b0, '0, rd);
      if (rd[1:0] !== STRAT_EVEN) sb.report($sformatf("strategy after reset is %0d", rd[1:0]));
      set_strategy(ADDR_UNMAPPED, STRAT_RTC);

      // even: nothing ready, only idle ready, wrap-around, top slot, unused current, then commands with no result
      send_fields(CMD_SCHEDULE, 8'h00, 1'b0, 3'd0, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'h01, 1'b0, 3'd3, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'hFF, 1'b0, 3'd7, 3'd7, '1);
      send_fields(CMD_SCHEDULE, 8'h80, 1'b0, 3'd0, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'h42, 1'b1, 3'd1, 3'd0, 64'h0);
      send_fields(CMD_UNKNOWN, 8'hFF, 1'b1, 3'd7, 3'd7, '1);
      send_fields(CMD_CLEAR_AGE, 8'h00, 1'b0, 3'd0, 3'd7, 64'h0);
      send_fields(CMD_RESET_STATE, 8'h00, 1'b0, 3'd0, 3'd0, 64'h0);

      // round robin: load a three-tick slice, hold it twice, then an unused current slot
      set_strategy(ADDR_STRATEGY, STRAT_RR);
      send_fields(CMD_RESET_STATE, 8'h00, 1'b0, 3'd2, 3'd0, 64'h0000_0000_0003_0200);
      send_fields(CMD_SCHEDULE, 8'h0C, 1'b0, 3'd2, 3'd0, 64'h0000_0000_0003_0200);
      send_fields(CMD_SCHEDULE, 8'h0C, 1'b0, 3'd2, 3'd0, 64'h0000_0000_0003_0200);
      send_fields(CMD_SCHEDULE, 8'hF0, 1'b1, 3'd3, 3'd0, '1);

      // aging: equal ages and priorities go to the lower slot, then the older slot wins
      set_strategy(ADDR_STRATEGY, STRAT_AGING);
      send_fields(CMD_SCHEDULE, 8'h0E, 1'b0, 3'd0, 3'd0, 64'h0505_0505_0505_0505);
      send_fields(CMD_RESET_STATE, 8'h00, 1'b0, 3'd0, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'h06, 1'b0, 3'd0, 3'd0, 64'h0000_0000_0009_0300);
      send_fields(CMD_CLEAR_AGE, 8'h00, 1'b0, 3'd0, 3'd2, 64'h0);
      send_fields(CMD_SCHEDULE, 8'hFF, 1'b0, 3'd5, 3'd0, '1);

      // run to completion: keep a ready current slot, move off a blocked one
      set_strategy(ADDR_STRATEGY, STRAT_RTC);
      send_fields(CMD_SCHEDULE, 8'h10, 1'b0, 3'd4, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'h21, 1'b0, 3'd4, 3'd0, 64'h0);
      send_fields(CMD_SCHEDULE, 8'h03, 1'b0, 3'd0, 3'd0, 64'h0);

      for (int p = 0; p < PHASES; p++) begin
         set_strategy(ADDR_STRATEGY, 2'(p % 4));
         case ((p + p / 4) % 4)
            0:       idle_pct = 0;
            1:       idle_pct = 56;
            2:       idle_pct = 0;
            default: idle_pct = 15;
         endcase
         for (int i = 0; i < REQUESTS_PER_PHASE; i++) begin
            if (i == REQUESTS_PER_PHASE / 2) begin
               // hold off until the block has answered everything
               start <= 1'b0;
               @(posedge clock);
               while (sb.pending_picks.size() != 0) @(posedge clock);
            end
            gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
            send_request(random_request(), gap);
         end
      end

      drain();
      $display("Sent %0d requests under all four strategies, %0d register writes;",
               requests_sent, csr_writes);
      $display("checked %0d slot picks, %0d mismatches.", sb.picks_checked, sb.errors);
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
